>>> rtl/pntg_pkg.sv
// Package for the piano note tone generator: constants, state codes, the key
// frequency table and the elaboration-time sine builder.
// Depends on nothing; used by rtl/piano_note_tone_generator.sv.
package pntg_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int NOTE_COUNT         = 88;

    localparam int NOTE_W    = 7;
    localparam int RATE_W    = 18;
    localparam int VOL_W     = 7;
    localparam int SAMPLE_W  = 8;
    localparam int FREQ_W    = 23;
    localparam int FRAC_BITS = 10;
    localparam int MAG_W     = 15;
    localparam int LEVEL_W   = 16;
    localparam int SINE_FRAC = 14;
    localparam int ACC_W     = LEVEL_W + VOL_W;
    localparam int CFG_W     = RATE_W;

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(8000);
    localparam logic [VOL_W-1:0]   VOL_RESET  = VOL_W'(127);
    localparam logic [LEVEL_W-1:0] LEVEL_MID  = LEVEL_W'(16384);

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    typedef enum logic {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_VOLUME      = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ROM,
        ST_LEVEL,
        ST_MAC,
        ST_DONE
    } gen_state_t;

    // Key frequencies in Q13.10, A0 to C8.
    localparam logic [FREQ_W-1:0] KEY_FREQ_Q10 [NOTE_COUNT] = '{
        23'd28160,   23'd29834,   23'd31609,   23'd33488,
        23'd35479,   23'd37589,   23'd39824,   23'd42192,
        23'd44701,   23'd47359,   23'd50175,   23'd53157,
        23'd56320,   23'd59669,   23'd63217,   23'd66976,
        23'd70959,   23'd75178,   23'd79648,   23'd84385,
        23'd89402,   23'd94719,   23'd100351,  23'd106318,
        23'd112640,  23'd119338,  23'd126434,  23'd133953,
        23'd141917,  23'd150356,  23'd159297,  23'd168770,
        23'd178805,  23'd189437,  23'd200702,  23'd212636,
        23'd225280,  23'd238676,  23'd252869,  23'd267905,
        23'd283835,  23'd300713,  23'd318594,  23'd337539,
        23'd357609,  23'd378874,  23'd401403,  23'd425272,
        23'd450560,  23'd477352,  23'd505736,  23'd535809,
        23'd567670,  23'd601426,  23'd637188,  23'd675077,
        23'd715219,  23'd757749,  23'd802807,  23'd850544,
        23'd901120,  23'd954704,  23'd1011473, 23'd1071616,
        23'd1135340, 23'd1202852, 23'd1274378, 23'd1350154,
        23'd1430436, 23'd1515500, 23'd1605612, 23'd1701089,
        23'd1802240, 23'd1909412, 23'd2022943, 23'd2143232,
        23'd2270679, 23'd2405704, 23'd2548756, 23'd2700308,
        23'd2860882, 23'd3030999, 23'd3211223, 23'd3402179,
        23'd3604480, 23'd3818813, 23'd4045896, 23'd4286474
    };

    // Keys past the top of the keyboard, silence included, have zero frequency.
    function automatic logic [FREQ_W-1:0] freq_of(input logic [NOTE_W-1:0] key);
        logic [FREQ_W-1:0] f;
        f = '0;
        if (key < NOTE_W'(NOTE_COUNT))
        begin
            f = KEY_FREQ_Q10[key];
        end
        return f;
    endfunction

    // Magnitude of one first-quadrant sine entry in Q1.14, from a Taylor series
    // in Q30. Evaluated only while the design elaborates.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned u,
                                                      input int unsigned abits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (longint'(u) * 64'd2 * PI_Q30) >> abits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        return MAG_W'((sum + 64'sd32768) >>> 16);
    endfunction

endpackage

>>> rtl/piano_note_tone_generator.sv
// Piano note tone generator: sine oscillator giving one 8-bit sample per tick.
// Depends on rtl/pntg_pkg.sv for constants, state codes and tables.
//
//   channel   direction  handshake                    payload
//   tick      in         tick_valid / tick_ready      note[6:0], start_tone
//   sample    out        sample_valid / sample_ready  sample[7:0]
//   config    in         cfg_we (no wait)             cfg_index, cfg_data[17:0]
//
// A tick without start_tone passes ST_ROM, ST_LEVEL, ST_MAC and ST_DONE; in
// ST_MAC the bit-serial phase adder works one bit a cycle.
// A tick with start_tone first runs the restoring divider, which yields one
// quotient bit a cycle, in ST_DIVIDE (skipped when the sample rate is zero).
// A new tick is taken as soon as the previous sample sits in the output
// register; a stalled output holds the finished sample in the last state.
// Reset (rst_n low, asynchronous) clears phase and step and loads the default
// sample rate and volume.
module piano_note_tone_generator
    import pntg_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_ready,
    input  logic [NOTE_W-1:0]   note,
    input  logic                start_tone,
    output logic                sample_valid,
    input  logic                sample_ready,
    output logic [SAMPLE_W-1:0] sample,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int QB       = SINE_ADDR_BITS - 2;
    localparam int QUARTER  = 1 << QB;
    localparam int DIV_BITS = FREQ_W + PHASE_BITS - FRAC_BITS;
    localparam int CNT_W    = $clog2(DIV_BITS);

    // First-quadrant magnitudes, both ends included.
    logic [MAG_W-1:0] qsine_rom [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_rom
        assign qsine_rom[g] = quarter_sine(int'(g), SINE_ADDR_BITS);
    end

    gen_state_t              state_reg, state_next;
    logic [RATE_W-1:0]       rate_reg;
    logic [VOL_W-1:0]        volume_reg;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [PHASE_BITS-1:0]   step_reg, step_next;
    logic [DIV_BITS-1:0]     div_reg, div_next;
    logic [RATE_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    carry_reg, carry_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [LEVEL_W-1:0]      level_reg, level_next;
    logic [VOL_W-1:0]        vol_reg, vol_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [SAMPLE_W-1:0]     sample_reg, sample_next;
    logic                    sample_valid_reg, sample_valid_next;

    logic [1:0]              quad;
    logic [QB-1:0]           rem_addr;
    logic [QB:0]             rom_index;
    logic [RATE_W:0]         trial;
    logic                    q_bit;
    logic                    sum_bit;

    assign tick_ready   = (state_reg == ST_IDLE);
    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;

    // Quarter-wave folding of the top phase bits.
    assign quad      = phase_reg[PHASE_BITS-1 -: 2];
    assign rem_addr  = phase_reg[PHASE_BITS-3 -: QB];
    assign rom_index = quad[0] ? ((QB+1)'(QUARTER) - {1'b0, rem_addr}) : {1'b0, rem_addr};

    assign trial   = {rem_reg, div_reg[DIV_BITS-1]};
    assign q_bit   = (trial >= {1'b0, rate_reg});
    assign sum_bit = phase_reg[0] ^ step_reg[0] ^ carry_reg;

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        step_next         = step_reg;
        div_next          = div_reg;
        rem_next          = rem_reg;
        cnt_next          = cnt_reg;
        carry_next        = carry_reg;
        mag_next          = mag_reg;
        neg_next          = neg_reg;
        level_next        = level_reg;
        vol_next          = vol_reg;
        acc_next          = acc_reg;
        sample_next       = sample_reg;
        sample_valid_next = sample_valid_reg;

        if (sample_valid_reg && sample_ready)
        begin
            sample_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid)
                begin
                    if (start_tone)
                    begin
                        phase_next = '0;
                        step_next  = '0;
                        div_next   = {freq_of(note), (PHASE_BITS-FRAC_BITS)'(0)};
                        rem_next   = '0;
                        cnt_next   = '0;
                        // A zero sample rate leaves the step at zero.
                        state_next = (rate_reg == '0) ? ST_ROM : ST_DIVIDE;
                    end
                    else
                    begin
                        state_next = ST_ROM;
                    end
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = q_bit ? RATE_W'(trial - {1'b0, rate_reg}) : RATE_W'(trial);
                step_next = {step_reg[PHASE_BITS-2:0], q_bit};
                div_next  = {div_reg[DIV_BITS-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_BITS - 1))
                begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM:
            begin
                mag_next   = qsine_rom[rom_index];
                neg_next   = quad[1];
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                level_next = neg_reg ? (LEVEL_MID - LEVEL_W'(mag_reg))
                                     : (LEVEL_MID + LEVEL_W'(mag_reg));
                vol_next   = volume_reg;
                acc_next   = '0;
                carry_next = 1'b0;
                cnt_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                // Shift-add multiply, volume MSB first, alongside the serial
                // phase advance, which rotates the step back into place.
                if (cnt_reg < CNT_W'(VOL_W))
                begin
                    acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                             + (vol_reg[VOL_W-1] ? ACC_W'(level_reg) : '0);
                    vol_next = {vol_reg[VOL_W-2:0], 1'b0};
                end
                phase_next = {sum_bit, phase_reg[PHASE_BITS-1:1]};
                step_next  = {step_reg[0], step_reg[PHASE_BITS-1:1]};
                carry_next = (phase_reg[0] & step_reg[0]) | (phase_reg[0] & carry_reg)
                           | (step_reg[0] & carry_reg);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PHASE_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sample_valid_reg || sample_ready)
                begin
                    sample_next       = acc_reg[SINE_FRAC + SAMPLE_W - 1 : SINE_FRAC];
                    sample_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg         <= RATE_RESET;
            volume_reg       <= VOL_RESET;
            phase_reg        <= '0;
            step_reg         <= '0;
            cnt_reg          <= '0;
            carry_reg        <= 1'b0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SAMPLE_RATE: rate_reg   <= cfg_data[RATE_W-1:0];
                    CFG_VOLUME:      volume_reg <= cfg_data[VOL_W-1:0];
                endcase
            end
            phase_reg        <= phase_next;
            step_reg         <= step_next;
            cnt_reg          <= cnt_next;
            carry_reg        <= carry_next;
            sample_valid_reg <= sample_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        level_reg  <= level_next;
        vol_reg    <= vol_next;
        acc_reg    <= acc_next;
        sample_reg <= sample_next;
    end

    // A new sample appears only on leaving the final state.
    a_sample_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("sample beat raised outside the final state");

    // (sin + 1) * volume with volume at most 127 never reaches full scale.
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid_reg |-> sample_reg != 8'hFF)
        else $error("sample out of range");

    a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> state_reg != ST_IDLE)
        else $error("tick beat did not start work");

    a_start_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready && start_tone) |=> phase_reg == '0)
        else $error("start of tone did not clear the phase");

endmodule

>>> dv/piano_note_tone_generator_test.sv
// Self-checking testbench for the piano note tone generator: drives ticks and
// register writes, predicts every sample and compares it with the block's output.
// Depends on rtl/pntg_pkg.sv and rtl/piano_note_tone_generator.sv.
module piano_note_tone_generator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pntg_pkg::*;

    localparam int PHASE_W     = 32;
    localparam int LUT_ADDR_W  = 10;
    localparam int LUT_SIZE    = 1 << LUT_ADDR_W;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 200;
    localparam int RANDOM_ITEMS = 555;
    localparam longint unsigned PI_FIX30 = 64'd3373259426;

    // Key frequencies in Q13.10, A0 up to C8.
    localparam int unsigned KEY_PITCH_Q10 [88] = '{
        28160, 29834, 31609, 33488, 35479, 37589, 39824, 42192,
        44701, 47359, 50175, 53157, 56320, 59669, 63217, 66976,
        70959, 75178, 79648, 84385, 89402, 94719, 100351, 106318,
        112640, 119338, 126434, 133953, 141917, 150356, 159297, 168770,
        178805, 189437, 200702, 212636, 225280, 238676, 252869, 267905,
        283835, 300713, 318594, 337539, 357609, 378874, 401403, 425272,
        450560, 477352, 505736, 535809, 567670, 601426, 637188, 675077,
        715219, 757749, 802807, 850544, 901120, 954704, 1011473, 1071616,
        1135340, 1202852, 1274378, 1350154, 1430436, 1515500, 1605612, 1701089,
        1802240, 1909412, 2022943, 2143232, 2270679, 2405704, 2548756, 2700308,
        2860882, 3030999, 3211223, 3402179, 3604480, 3818813, 4045896, 4286474
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tick_valid = 1'b0;
    logic                tick_ready;
    logic [NOTE_W-1:0]   note = '0;
    logic                start_tone = 1'b0;
    logic                sample_valid;
    logic                sample_ready = 1'b0;
    logic [SAMPLE_W-1:0] sample;
    logic                cfg_we = 1'b0;
    cfg_index_t          cfg_index = CFG_SAMPLE_RATE;
    logic [CFG_W-1:0]    cfg_data = '0;

    // Mirror of the block's state and registers.
    logic [PHASE_W-1:0]  phase_acc;
    logic [PHASE_W-1:0]  phase_inc;
    logic [RATE_W-1:0]   rate_reg;
    logic [VOL_W-1:0]    vol_reg;
    int                  sine_lut [LUT_SIZE];

    logic [SAMPLE_W-1:0] expected_samples [$];
    logic [SAMPLE_W-1:0] wanted;
    int                  errors = 0;
    int                  cycle_count = 0;
    int                  send_idle_pct = 31;
    int                  recv_idle_pct = 80;
    int                  hold_left = 0;

    piano_note_tone_generator dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .note         (note),
        .start_tone   (start_tone),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6;
        clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Sink side: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            sample_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            sample_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: sample beat with none expected, expected none, actual %0d",
                         $time, sample);
                errors = errors + 1;
            end
            else
            begin
                wanted = expected_samples.pop_front();
                if (sample !== wanted)
                begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, wanted, sample);
                    errors = errors + 1;
                end
            end
        end
    end

    // One Q1.14 sine entry: quarter-wave folding and a Taylor series in Q30.
    function automatic int sine_q14_entry(input int unsigned k);
        int unsigned     quad;
        int unsigned     rem;
        int unsigned     u;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint          acc;
        int              v;
        int              n;
        quad = (k >> (LUT_ADDR_W - 2)) & 3;
        rem  = k & ((1 << (LUT_ADDR_W - 2)) - 1);
        u    = quad[0] ? (1 << (LUT_ADDR_W - 2)) - rem : rem;
        x    = u;
        x    = (x * 2 * PI_FIX30) >> LUT_ADDR_W;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (n = 1; n <= 6; n++)
        begin
            divisor = (2 * n) * (2 * n + 1);
            term = ((term * x2) >> 30) / divisor;
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        v = int'((acc + 64'sd32768) >>> 16);
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic logic [PHASE_W-1:0] pitch_step(input logic [NOTE_W-1:0] k);
        longint unsigned num;
        if (k >= NOTE_COUNT || rate_reg == '0)
        begin
            return '0;
        end
        num = KEY_PITCH_Q10[k];
        num = num << (PHASE_W - 10);
        return PHASE_W'(num / rate_reg);
    endfunction

    // Sample for one tick; advances the mirrored phase.
    function automatic logic [SAMPLE_W-1:0] tone_sample(input logic [NOTE_W-1:0] k,
                                                        input logic s);
        int                  level;
        logic [SAMPLE_W-1:0] result;
        if (s)
        begin
            phase_acc = '0;
            phase_inc = pitch_step(k);
        end
        level  = sine_lut[phase_acc[PHASE_W-1 -: LUT_ADDR_W]] + 16384;
        result = SAMPLE_W'((level * int'(vol_reg)) >> 14);
        phase_acc = phase_acc + phase_inc;
        return result;
    endfunction

    task automatic send_tick(input logic [NOTE_W-1:0] k, input logic s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        tick_valid <= 1'b1;
        note       <= k;
        start_tone <= s;
        do
        begin
            @(posedge clk);
        end
        while (!tick_ready);
        expected_samples.push_back(tone_sample(k, s));
    endtask

    task automatic await_idle();
        tick_valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        await_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SAMPLE_RATE)
        begin
            rate_reg = data[RATE_W-1:0];
        end
        else
        begin
            vol_reg = data[VOL_W-1:0];
        end
    endtask

    // Before any start flag the step is zero, so the output sits at the volume.
    task automatic test_power_up();
        send_tick(NOTE_W'(48), 1'b0);
        send_tick(NOTE_W'(48), 1'b1);
        send_tick(NOTE_W'(5), 1'b0);
    endtask

    task automatic test_keyboard_ends();
        send_tick(NOTE_W'(0), 1'b1);
        send_tick(NOTE_W'(0), 1'b0);
        send_tick(NOTE_W'(87), 1'b1);
        send_tick(NOTE_W'(87), 1'b0);
        send_tick(NOTE_W'(88), 1'b1);
        send_tick(NOTE_W'(88), 1'b0);
        send_tick(NOTE_W'(127), 1'b1);
        send_tick(NOTE_W'(127), 1'b0);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_VOLUME, CFG_W'(0));
        send_tick(NOTE_W'(60), 1'b1);
        send_tick(NOTE_W'(60), 1'b0);
        // Volume data with every upper bit set: only the low seven bits count.
        write_reg(CFG_VOLUME, '1);
        // A new rate mid-tone must wait for the next start flag.
        write_reg(CFG_SAMPLE_RATE, CFG_W'(1000));
        send_tick(NOTE_W'(60), 1'b0);
        send_tick(NOTE_W'(60), 1'b1);
        write_reg(CFG_SAMPLE_RATE, CFG_W'(192000));
        send_tick(NOTE_W'(87), 1'b1);
        send_tick(NOTE_W'(87), 1'b0);
        // A zero rate gives a zero step, and a rate of one wraps the step.
        write_reg(CFG_SAMPLE_RATE, CFG_W'(0));
        send_tick(NOTE_W'(40), 1'b1);
        send_tick(NOTE_W'(40), 1'b0);
        write_reg(CFG_SAMPLE_RATE, CFG_W'(1));
        send_tick(NOTE_W'(33), 1'b1);
        send_tick(NOTE_W'(33), 1'b0);
        write_reg(CFG_SAMPLE_RATE, '1);
        send_tick(NOTE_W'(87), 1'b1);
        write_reg(CFG_SAMPLE_RATE, CFG_W'(8000));
    endtask

    task automatic pick_registers();
        int                  choice;
        logic [RATE_W-1:0]   rate;
        choice = $urandom_range(99);
        if (choice < 50)
        begin
            rate = RATE_W'($urandom_range(1000, 192000));
        end
        else if (choice < 60)
        begin
            rate = RATE_W'($urandom_range(0, 999));
        end
        else
        begin
            case ($urandom_range(4))
                0:       rate = RATE_W'(1000);
                1:       rate = RATE_W'(8000);
                2:       rate = RATE_W'(44100);
                3:       rate = RATE_W'(48000);
                default: rate = RATE_W'(192000);
            endcase
        end
        write_reg(CFG_SAMPLE_RATE, CFG_W'(rate));
        write_reg(CFG_VOLUME, CFG_W'($urandom));
    endtask

    // Mostly whole tones with random content, with stray and broken ticks mixed in.
    task automatic test_random_tones(input int send_pct, input int recv_pct);
        int                sent;
        int                len;
        int                next_config;
        logic [NOTE_W-1:0] key;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        next_config = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_config)
            begin
                pick_registers();
                next_config = sent + $urandom_range(80, 200);
            end
            if ($urandom_range(99) < 85)
            begin
                if ($urandom_range(19) == 0)
                begin
                    key = NOTE_W'($urandom_range(88, 127));
                end
                else
                begin
                    key = NOTE_W'($urandom_range(87));
                end
                send_tick(key, 1'b1);
                len = $urandom_range(2, 40);
                repeat (len)
                begin
                    if ($urandom_range(9) == 0)
                    begin
                        send_tick(NOTE_W'($urandom), 1'b0);
                    end
                    else
                    begin
                        send_tick(key, 1'b0);
                    end
                end
                sent = sent + len + 1;
            end
            else
            begin
                send_tick(NOTE_W'($urandom), 1'($urandom));
                sent = sent + 1;
            end
        end
    endtask

    // The sink holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        await_idle();
        hold_left = 1500;
        send_tick(NOTE_W'(52), 1'b1);
        repeat (23)
        begin
            send_tick(NOTE_W'(52), 1'b0);
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < LUT_SIZE; i++)
        begin
            sine_lut[i] = sine_q14_entry(i);
        end
        phase_acc = '0;
        phase_inc = '0;
        rate_reg  = RATE_W'(8000);
        vol_reg   = VOL_W'(127);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_keyboard_ends();
        test_register_extremes();
        test_random_tones(31, 80);
        test_random_tones(80, 31);
        test_random_tones(0, 0);
        test_backpressure();

        await_idle();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
